### rtl/core/mxh_pkg.sv
// ----------------------------------------------------------------------------
// mxh_pkg: shared types and constants of the multiply-xor hash core
// Holds the hash constants, controller state type and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mxh_pkg;

    localparam int unsigned HashW   = 64;
    localparam int unsigned HalfW   = 32;
    localparam int unsigned CountW  = 4;
    localparam int unsigned ByteIdxW = 3;

    localparam logic [HashW-1:0] SEED_VALUE = 64'hea24_ccba_9c79_03c6;
    localparam logic [HashW-1:0] WORD_MULT  = 64'h9492_da79_9b90_d331;
    localparam logic [HashW-1:0] BYTE_MULT  = 64'h8512_0a0a_fdd7_ee37;
    localparam int unsigned      FOLD_SHIFT = 32;

    localparam logic [CountW-1:0] FULL_COUNT = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_FINISH
    } mxh_state_t;

    // Which pair of 32-bit halves goes through the shared multiplier.
    typedef enum logic [1:0] {
        MS_LO_LO,
        MS_HI_LO,
        MS_LO_HI
    } mxh_mul_step_t;

    typedef struct packed {
        logic          load;
        logic          mul_en;
        mxh_mul_step_t mul_step;
        logic          mul_done;
        logic          emit;
    } mxh_cmd_t;

    typedef struct packed {
        logic in_empty;
        logic more_bytes;
        logic last;
        logic out_busy;
    } mxh_status_t;

endpackage

### rtl/core/mxh_datapath.sv
// ----------------------------------------------------------------------------
// mxh_datapath: running hash, shared multiplier and result register
// Computes each 64-bit product mod 2^64 from three 32x32 partial products on
// one multiplier, and folds the hash into the output register on command.
// ----------------------------------------------------------------------------
module mxh_datapath
    import mxh_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  mxh_cmd_t            cmd,
    output mxh_status_t         status,
    input  logic [HashW-1:0]    s_word_data,
    input  logic [CountW-1:0]   s_byte_count,
    input  logic                s_last_word,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [HashW-1:0]    m_hash_value
);

    logic [HashW-1:0]    hash_reg, hash_next;
    logic [HashW-1:0]    word_reg;
    logic [CountW-1:0]   count_reg;
    logic                full_reg;
    logic                last_reg;
    logic [ByteIdxW-1:0] idx_reg;
    logic [HashW-1:0]    oper_reg;
    logic [HashW-1:0]    acc_reg;
    logic                m_valid_reg, m_valid_next;
    logic [HashW-1:0]    m_hash_reg;

    logic                in_full;
    logic [HashW-1:0]    mult_const;
    logic [HalfW-1:0]    mul_a, mul_b;
    logic [HashW-1:0]    prod;
    logic [HalfW-1:0]    acc_hi_sum;
    logic [HashW-1:0]    mul_result;
    logic [7:0]          next_byte;
    logic                more_bytes;

    assign in_full    = (s_byte_count >= FULL_COUNT);
    assign mult_const = full_reg ? WORD_MULT : BYTE_MULT;

    always_comb begin
        case (cmd.mul_step)
            MS_LO_LO: begin
                mul_a = oper_reg[HalfW-1:0];
                mul_b = mult_const[HalfW-1:0];
            end
            MS_HI_LO: begin
                mul_a = oper_reg[HashW-1:HalfW];
                mul_b = mult_const[HalfW-1:0];
            end
            MS_LO_HI: begin
                mul_a = oper_reg[HalfW-1:0];
                mul_b = mult_const[HashW-1:HalfW];
            end
            default: begin
                mul_a = oper_reg[HalfW-1:0];
                mul_b = mult_const[HalfW-1:0];
            end
        endcase
    end

    assign prod       = HashW'(mul_a) * HashW'(mul_b);
    // The cross terms only reach the upper half of the truncated product.
    assign acc_hi_sum = acc_reg[HashW-1:HalfW] + prod[HalfW-1:0];
    assign mul_result = {acc_hi_sum, acc_reg[HalfW-1:0]};

    assign next_byte  = word_reg[8*idx_reg +: 8];
    assign more_bytes = !full_reg && (CountW'(idx_reg) < count_reg);

    always_comb begin
        hash_next = hash_reg;
        if (cmd.emit) begin
            hash_next = SEED_VALUE;
        end else if (cmd.mul_done) begin
            hash_next = mul_result;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg    <= SEED_VALUE;
            m_valid_reg <= 1'b0;
        end else begin
            hash_reg    <= hash_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            word_reg  <= s_word_data;
            count_reg <= s_byte_count;
            full_reg  <= in_full;
            last_reg  <= s_last_word;
            idx_reg   <= ByteIdxW'(1);
            oper_reg  <= hash_reg ^ (in_full ? s_word_data : HashW'(s_word_data[7:0]));
        end else if (cmd.mul_done && more_bytes) begin
            idx_reg  <= idx_reg + ByteIdxW'(1);
            oper_reg <= mul_result ^ HashW'(next_byte);
        end
        if (cmd.mul_en) begin
            if (cmd.mul_step == MS_LO_LO) begin
                acc_reg <= prod;
            end else begin
                acc_reg <= mul_result;
            end
        end
        if (cmd.emit) begin
            m_hash_reg <= hash_reg ^ (hash_reg >> FOLD_SHIFT);
        end
    end

    assign status.in_empty   = (s_byte_count == '0);
    assign status.more_bytes = more_bytes;
    assign status.last       = last_reg;
    assign status.out_busy   = m_valid_reg && !m_ready;

    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_reg;

endmodule

### rtl/core/mxh_ctrl.sv
// ----------------------------------------------------------------------------
// mxh_ctrl: sequencing state machine of the multiply-xor hash core
// Takes one word, steps the shared multiplier through its three partial
// products once per multiply, and hands the folded hash to the output.
// ----------------------------------------------------------------------------
module mxh_ctrl
    import mxh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  mxh_status_t status,
    output mxh_cmd_t    cmd,
    output mxh_state_t  state
);

    mxh_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = status.in_empty ? ST_FINISH : ST_MUL0;
                end
            end
            ST_MUL0: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = status.more_bytes ? ST_MUL0 : ST_FINISH;
            ST_FINISH: begin
                if (!(status.last && status.out_busy)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.mul_step = MS_LO_LO;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_MUL0: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = MS_LO_LO;
            end
            ST_MUL1: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = MS_HI_LO;
            end
            ST_MUL2: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = MS_LO_HI;
                cmd.mul_done = 1'b1;
            end
            ST_FINISH: begin
                cmd.emit = status.last && !status.out_busy;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign state = state_reg;

endmodule

### rtl/core/multiply_xor_hash_64_core.sv
// ----------------------------------------------------------------------------
// multiply_xor_hash_64_core: streaming multiply-xor 64-bit key hash
// Hashes a key sent as 64-bit little-endian words and returns the folded
// hash after the last word.
//
//   channel | ports                                   | dir | beat
//   --------+-----------------------------------------+-----+---------------
//   s_      | s_valid s_ready s_word_data s_byte_count | in  | one key word
//           | s_last_word                             |     |
//   m_      | m_valid m_ready m_hash_value            | out | one key hash
//
// A full word steps through accept, three multiplier passes and finish. A
// short word runs one multiply per valid byte. Each 64-bit multiply
// runs as three 32x32 partial products on one shared multiplier.
// Reset loads the seed and empties the output register.
// A last word whose result finds the output register still full waits in the
// finish step until the previous hash is taken; other words never wait on m_.
// ----------------------------------------------------------------------------
module multiply_xor_hash_64_core
    import mxh_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [HashW-1:0]    s_word_data,
    input  logic [CountW-1:0]   s_byte_count,
    input  logic                s_last_word,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [HashW-1:0]    m_hash_value
);

    mxh_cmd_t    cmd;
    mxh_status_t status;
    mxh_state_t  state;

    mxh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd),
        .state   (state)
    );

    mxh_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_word_data  (s_word_data),
        .s_byte_count (s_byte_count),
        .s_last_word  (s_last_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hash_value (m_hash_value)
    );

    // Once a beat is taken, s_ready is low in the next cycle.
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready
    ) else $error("input taken again right after an accepted beat");

    // A full word that is not last runs exactly three multiplier passes.
    a_full_word_latency: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_byte_count[3] && !s_last_word) |-> ##5 s_ready
    ) else $error("full word did not finish in the expected cycle count");

    // A new result only comes out of the finish step.
    a_result_from_finish: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state == ST_FINISH)
    ) else $error("result raised outside the finish step");

endmodule
